// ----- hw/rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the double-ended queue
package dq_pkg;

  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int FILL_W        = 5;
  localparam int DEPTH_DEFAULT = 16;

  localparam logic [DATA_W-1:0] FAIL_WORD = {DATA_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } dq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } dq_status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SWEEP = 1'b1
  } dq_state_t;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic write_rear;
  } dq_cell_ctl_t;

endpackage

// ----- hw/rtl/dq_if.sv -----
`timescale 1ns / 1ps
// item channels of the double-ended queue
interface dq_in_if;
  logic                          valid;
  logic                          ready;
  logic [dq_pkg::FUNC_W-1:0]     func;
  logic signed [dq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, func, push_value, input ready);
  modport sink   (input valid, func, push_value, output ready);
endinterface

interface dq_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dq_pkg::DATA_W-1:0] pop_value;
  logic [dq_pkg::STATUS_W-1:0]      status;
  logic                             is_empty;
  logic [dq_pkg::FILL_W-1:0]        fill_count;

  modport source (output valid, pop_value, status, is_empty, fill_count, input ready);
  modport sink   (input valid, pop_value, status, is_empty, fill_count, output ready);
endinterface

// ----- hw/rtl/dq_cell.sv -----
`timescale 1ns / 1ps
// one storage cell of the queue row, with its slot of the rear-value carry chain
module dq_cell #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  dq_pkg::dq_cell_ctl_t      ctl,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  logic [dq_pkg::DATA_W-1:0] push_value,
  input  logic [dq_pkg::DATA_W-1:0] left_data,
  input  logic [dq_pkg::DATA_W-1:0] right_data,
  input  logic [dq_pkg::DATA_W-1:0] carry_in,
  output logic [dq_pkg::DATA_W-1:0] data,
  output logic [dq_pkg::DATA_W-1:0] carry
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic rear_slot;
  logic last_used;

  // first free slot takes a rear push, the slot below it holds the rear item
  assign rear_slot = (count == CNT_W'(IDX));
  assign last_used = (count == CNT_W'(IDX + 1));

  always_ff @(posedge clk) begin
    priority if (ctl.shift_right) begin
      data <= left_data;
    end else if (ctl.shift_left) begin
      data <= right_data;
    end else if (ctl.write_rear && rear_slot) begin
      data <= push_value;
    end else begin
      data <= data;
    end
  end

  // rear item walks one cell towards the front each cycle
  always_ff @(posedge clk) begin
    carry <= last_used ? data : carry_in;
  end

endmodule

// ----- hw/rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// top level: double-ended queue built as a shifting row of storage cells
// push front, push rear, pop front and failed ops load their item into the output register in the cycle after accept
// pop rear on a non-empty queue waits in the sweep state while the rear item ripples to cell 0
// through the carry chain, one cell per cycle, and no new item is taken meanwhile
// throughput: one item per cycle except during a rear-pop sweep or while rsp holds back a full output register
// reset (rst, synchronous, active high) empties the queue and the output register; cells keep data
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  dq_in_if.sink    cmd,
  dq_out_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH+1);

  // queue state: front item always sits in cell 0, count gives the fill level
  dq_pkg::dq_state_t     state;
  dq_pkg::dq_state_t     state_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      sweep_cnt;

  // output register
  logic                       out_valid;
  logic [dq_pkg::DATA_W-1:0]  out_value;
  dq_pkg::dq_status_t         out_status;
  logic                       out_empty;
  logic [dq_pkg::FILL_W-1:0]  out_fill;

  // cell row
  logic [dq_pkg::DATA_W-1:0] cell_data  [DEPTH];
  logic [dq_pkg::DATA_W-1:0] cell_carry [DEPTH];
  dq_pkg::dq_cell_ctl_t      ctl;

  // per-cycle decode
  dq_pkg::dq_op_t            op;
  logic                      slot_free;
  logic                      accept;
  logic                      is_full;
  logic                      is_empty_now;
  logic                      sweep_start;
  logic                      sweep_done;
  logic                      load_out;
  logic [dq_pkg::DATA_W-1:0] res_value;
  dq_pkg::dq_status_t        res_status;

  assign op           = dq_pkg::dq_op_t'(cmd.func);
  assign slot_free    = !out_valid || rsp.ready;
  // no item is taken while reset is held
  assign cmd.ready    = !rst && (state == dq_pkg::S_IDLE) && slot_free;
  assign accept       = cmd.valid && cmd.ready;
  assign is_full      = (count == CNT_W'(DEPTH));
  assign is_empty_now = (count == '0);
  // carry of cell 0 holds the rear item once the sweep counter runs out
  assign sweep_done   = (state == dq_pkg::S_SWEEP) && (sweep_cnt == '0) && slot_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dq_pkg::S_IDLE: begin
        if (sweep_start) begin
          state_next = dq_pkg::S_SWEEP;
        end
      end
      dq_pkg::S_SWEEP: begin
        if (sweep_done) begin
          state_next = dq_pkg::S_IDLE;
        end
      end
      default: state_next = dq_pkg::S_IDLE;
    endcase
  end

  // operation decode: cell commands, result item and new fill level
  always_comb begin
    ctl         = '0;
    load_out    = 1'b0;
    sweep_start = 1'b0;
    res_value   = dq_pkg::FAIL_WORD;
    res_status  = dq_pkg::ST_OK;
    count_next  = count;
    if (accept) begin
      unique case (op)
        dq_pkg::OP_PUSH_FRONT: begin
          load_out = 1'b1;
          if (is_full) begin
            res_status = dq_pkg::ST_FULL;
          end else begin
            ctl.shift_right = 1'b1;
            count_next      = count + CNT_W'(1);
          end
        end
        dq_pkg::OP_PUSH_REAR: begin
          load_out = 1'b1;
          if (is_full) begin
            res_status = dq_pkg::ST_FULL;
          end else begin
            ctl.write_rear = 1'b1;
            count_next     = count + CNT_W'(1);
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          load_out = 1'b1;
          if (is_empty_now) begin
            res_status = dq_pkg::ST_EMPTY;
          end else begin
            res_value      = cell_data[0];
            ctl.shift_left = 1'b1;
            count_next     = count - CNT_W'(1);
          end
        end
        dq_pkg::OP_POP_REAR: begin
          if (is_empty_now) begin
            load_out   = 1'b1;
            res_status = dq_pkg::ST_EMPTY;
          end else begin
            // rear item still has to ripple down to cell 0
            sweep_start = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (sweep_done) begin
      load_out   = 1'b1;
      res_value  = cell_carry[0];
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dq_pkg::S_IDLE;
      count     <= '0;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (sweep_start) begin
        sweep_cnt <= count - CNT_W'(1);
      end else if ((state == dq_pkg::S_SWEEP) && (sweep_cnt != '0)) begin
        sweep_cnt <= sweep_cnt - CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_empty  <= (count_next == '0);
      out_fill   <= dq_pkg::FILL_W'(count_next);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.pop_value  = out_value;
  assign rsp.status     = out_status;
  assign rsp.is_empty   = out_empty;
  assign rsp.fill_count = out_fill;

  // the cell row: cell 0 is the front, neighbours pass data both ways
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [dq_pkg::DATA_W-1:0] left_data;
    logic [dq_pkg::DATA_W-1:0] right_data;
    logic [dq_pkg::DATA_W-1:0] carry_in;

    if (i == 0) begin : g_front
      assign left_data = cmd.push_value;
    end else begin : g_mid_left
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_data = cell_data[i];
      assign carry_in   = cell_data[i];
    end else begin : g_mid_right
      assign right_data = cell_data[i+1];
      assign carry_in   = cell_carry[i+1];
    end

    dq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .push_value (cmd.push_value),
      .left_data  (left_data),
      .right_data (right_data),
      .carry_in   (carry_in),
      .data       (cell_data[i]),
      .carry      (cell_carry[i])
    );
  end

  // fill level never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill level above capacity");

  // no new item while the rear sweep is running
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == dq_pkg::S_SWEEP) |-> !cmd.ready)
    else $error("item taken during rear sweep");

  // a push on a full queue must leave the fill level alone
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (accept && is_full && (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_REAR))
    |=> $stable(count))
    else $error("dropped push changed the fill level");

  // a finished sweep always yields a result item and one fewer entry
  a_sweep_result: assert property (@(posedge clk) disable iff (rst)
    sweep_done |=> (rsp.valid && (count == $past(count) - CNT_W'(1))))
    else $error("rear sweep finished without result");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the double-ended queue
module tb_top;
  import dq_pkg::*;

  localparam int DEPTH       = DEPTH_DEFAULT;
  localparam int RESET_LEN   = 11;
  localparam int RANDOM_LEN  = 1000;
  localparam int CALM_LEN    = 150;      // tail of the run with no idling
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 4000;
  localparam int MAX_PRINTS  = 40;

  // one expected response item
  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    dq_status_t        status;
    logic              is_empty;
    logic [FILL_W-1:0] fill_count;
  } dq_result_t;

  // shadow deque: kept as a ring buffer, queues the responses it implies
  class deque_scoreboard;
    logic [DATA_W-1:0] ring_copy [DEPTH];
    int unsigned       front_at;
    int unsigned       rear_at;
    int unsigned       held_count;
    dq_result_t        pending_results [$];
    int                errors;

    function new();
      front_at   = 0;
      rear_at    = 0;
      held_count = 0;
      errors     = 0;
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // work out the response an accepted command item will produce
    function void note_item(input dq_op_t op, input logic [DATA_W-1:0] word);
      dq_result_t res;
      res.pop_value = FAIL_WORD;
      res.status    = ST_OK;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (held_count >= DEPTH) begin
            res.status = ST_FULL;
          end else if (op == OP_PUSH_FRONT) begin
            front_at = (front_at == 0) ? DEPTH - 1 : front_at - 1;
            ring_copy[front_at] = word;
            held_count++;
          end else begin
            ring_copy[rear_at] = word;
            rear_at = (rear_at + 1 >= DEPTH) ? 0 : rear_at + 1;
            held_count++;
          end
        end
        default: begin
          if (held_count == 0) begin
            res.status = ST_EMPTY;
          end else if (op == OP_POP_FRONT) begin
            res.pop_value = ring_copy[front_at];
            front_at = (front_at + 1 >= DEPTH) ? 0 : front_at + 1;
            held_count--;
          end else begin
            rear_at = (rear_at == 0) ? DEPTH - 1 : rear_at - 1;
            res.pop_value = ring_copy[rear_at];
            held_count--;
          end
        end
      endcase
      res.is_empty   = (held_count == 0);
      res.fill_count = held_count[FILL_W-1:0];
      pending_results.push_back(res);
    endfunction

    task check_result(input logic [DATA_W-1:0] pop_value, input logic [STATUS_W-1:0] status,
                      input logic is_empty, input logic [FILL_W-1:0] fill_count);
      dq_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected item pop_value=%h status=%0d", pop_value, status));
      end else begin
        want = pending_results.pop_front();
        if (pop_value !== want.pop_value || status !== want.status ||
            is_empty !== want.is_empty || fill_count !== want.fill_count)
          report($sformatf("got value=%h st=%0d empty=%b fill=%0d, want %h %0d %b %0d",
                           pop_value, status, is_empty, fill_count, want.pop_value,
                           want.status, want.is_empty, want.fill_count));
      end
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm;        // set for the closing stretch: no idling either side
  int   cycles;

  deque_scoreboard sb;

  dq_in_if  cmd ();
  dq_out_if rsp ();

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd.sink),
    .rsp (rsp.source)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // both handshakes are sampled at the edge; the response to a command item
  // can never land on the same edge that accepted it
  always @(posedge clk) begin
    if (!rst && cmd.valid && cmd.ready)
      sb.note_item(dq_op_t'(cmd.func), cmd.push_value);
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(rsp.pop_value, rsp.status, rsp.is_empty, rsp.fill_count);
  end

  // response side back-pressure: random stall bursts of random length
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // offer one command item, maybe after a gap, and hold it until taken
  task automatic send_item(input dq_op_t op, input logic [DATA_W-1:0] word);
    if (!calm && $urandom_range(0, 5) == 0) begin
      // gap: valid low, junk on the payload which must be ignored
      cmd.valid      <= 1'b0;
      cmd.func       <= FUNC_W'($urandom);
      cmd.push_value <= $urandom;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd.valid      <= 1'b1;
    cmd.func       <= op;
    cmd.push_value <= word;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  // payload mix: extremes and small values often, otherwise any 32 bits
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return FAIL_WORD;
      3:       return '0;
      4:       return DATA_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // modes: 0 push-heavy, 1 pop-heavy, 2 balanced, 3 rear-end heavy
  function automatic dq_op_t pick_op(input int mode);
    int  roll;
    logic is_pop;
    logic at_rear;
    roll    = $urandom_range(0, 99);
    at_rear = ($urandom_range(0, 1) != 0);
    case (mode)
      0:       is_pop = (roll >= 75);
      1:       is_pop = (roll < 75);
      3: begin
        is_pop  = (roll < 50);
        at_rear = ($urandom_range(0, 9) != 0);
      end
      default: is_pop = (roll < 50);
    endcase
    if (is_pop) return at_rear ? OP_POP_REAR : OP_POP_FRONT;
    return at_rear ? OP_PUSH_REAR : OP_PUSH_FRONT;
  endfunction

  initial begin
    logic [DATA_W-1:0] pattern [8];
    int mode;
    int phase_left;
    int drain;

    sb = new();
    cmd.valid      <= 1'b0;
    cmd.func       <= OP_PUSH_FRONT;
    cmd.push_value <= '0;
    pattern = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
                32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hfffe_0001};

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: pops on an empty queue from both ends
    send_item(OP_POP_FRONT, 32'h1234_5678);
    send_item(OP_POP_REAR, 32'h8765_4321);
    // push front from head 0 wraps the head backwards; pop from the far ends
    send_item(OP_PUSH_FRONT, 32'h8000_0000);
    send_item(OP_PUSH_REAR, 32'h7fff_ffff);
    send_item(OP_POP_REAR, '0);
    send_item(OP_POP_FRONT, '0);
    // fill the ring from both ends, then push into a full queue at both ends
    for (int i = 0; i < DEPTH; i++)
      send_item(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, pattern[i % 8]);
    send_item(OP_PUSH_FRONT, 32'hdead_beef);
    send_item(OP_PUSH_REAR, 32'hcafe_f00d);
    // a full-depth rear pop is the slowest case
    send_item(OP_POP_REAR, '0);
    send_item(OP_POP_FRONT, '0);

    // random: phases of varying op mix so the queue swings between empty and full
    mode       = 0;
    phase_left = 0;
    for (int n = 0; n < RANDOM_LEN; n++) begin
      if (n == RANDOM_LEN - CALM_LEN) calm = 1'b1;
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      send_item(pick_op(mode), pick_word());
    end
    cmd.valid <= 1'b0;

    // drain, then allow a full rear-pop sweep before the final verdict
    drain = 0;
    while (sb.outstanding() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (DEPTH + 4) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d expected items never arrived", sb.outstanding()));

    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- double_ended_queue.f -----
hw/rtl/dq_pkg.sv
hw/rtl/dq_if.sv
hw/rtl/dq_cell.sv
hw/rtl/double_ended_queue.sv
sim/tb_top.sv
